### sv/q2e_pkg.sv
// Shared constants, types and the arctangent table for the quaternion to Euler angle unit.
package q2e_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN = 24;
  localparam int RUN_STAGES = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int SQRT_STAGES = 29;
  localparam int STG_W = 5;
  localparam int CW = 38;
  localparam int AW = 34;
  localparam int VW = 57;
  localparam int RW = 58;
  localparam int SW = 30;
  localparam int PW = 32;
  localparam int NV = 3 + SQRT_STAGES + 1 + RUN_STAGES;

  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
  } cordic_t;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [RW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y3;
    logic signed [CW-1:0] x3;
    logic signed [SW-1:0] s;
    logic                 clamp;
  } side_t;

  function automatic logic signed [AW-1:0] atan_entry(input logic [STG_W-1:0] idx);
    logic signed [AW-1:0] r;
    case (idx)
      5'd0:  r = AW'(34'h020000000);
      5'd1:  r = AW'(34'h012E4051E);
      5'd2:  r = AW'(34'h009FB385B);
      5'd3:  r = AW'(34'h0051111D4);
      5'd4:  r = AW'(34'h0028B0D43);
      5'd5:  r = AW'(34'h00145D7E1);
      5'd6:  r = AW'(34'h000A2F61E);
      5'd7:  r = AW'(34'h000517C55);
      5'd8:  r = AW'(34'h00028BE53);
      5'd9:  r = AW'(34'h000145F2F);
      5'd10: r = AW'(34'h0000A2F98);
      5'd11: r = AW'(34'h0000517CC);
      5'd12: r = AW'(34'h000028BE6);
      5'd13: r = AW'(34'h0000145F3);
      5'd14: r = AW'(34'h00000A2FA);
      5'd15: r = AW'(34'h00000517D);
      5'd16: r = AW'(34'h0000028BE);
      5'd17: r = AW'(34'h00000145F);
      5'd18: r = AW'(34'h000000A30);
      5'd19: r = AW'(34'h000000518);
      5'd20: r = AW'(34'h00000028C);
      5'd21: r = AW'(34'h000000146);
      5'd22: r = AW'(34'h0000000A3);
      5'd23: r = AW'(34'h000000051);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/q2e_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module q2e_sqrt_cell import q2e_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [STG_W-1:0] stage,
  input  sqrt_t            d_in,
  output sqrt_t            d_out
);

  logic [STG_W-1:0] rev;
  logic [RW-1:0]    bitv;
  logic [RW-1:0]    t;
  sqrt_t            d_nxt;
  sqrt_t            d_r;

  always_comb begin
    rev = STG_W'(SQRT_STAGES - 1) - stage;
    bitv = RW'(1) << {rev, 1'b0};
    t = d_in.res + bitv;
    if ({1'b0, d_in.v} >= t) begin
      d_nxt.v = VW'({1'b0, d_in.v} - t);
      d_nxt.res = (d_in.res >> 1) + bitv;
    end else begin
      d_nxt.v = d_in.v;
      d_nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

### sv/q2e_cordic_cell.sv
// One vectoring micro-rotation cell of the CORDIC arctangent chain.
module q2e_cordic_cell import q2e_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [STG_W-1:0] stage,
  input  cordic_t          d_in,
  output cordic_t          d_out
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  cordic_t              d_nxt;
  cordic_t              d_r;

  always_comb begin
    xs = d_in.x >>> stage;
    ys = d_in.y >>> stage;
    d_nxt.zero = d_in.zero;
    if (!d_in.y[CW-1]) begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.acc = d_in.acc + atan_entry(stage);
    end else begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.acc = d_in.acc - atan_entry(stage);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

### sv/quaternion_to_euler_xyz_unit.sv
// Quaternion to x-y-z Euler angle converter, top level.
// Accepts one quaternion per clock cycle while the output is not stalled and
// returns each result through the product and side registers, the 29 digit
// cells of the square root, the prerotation register, the CORDIC cell chains
// and the output register. The whole pipeline holds while a finished result is
// stalled at the output, so a stalled output also stalls the input.
module quaternion_to_euler_xyz_unit import q2e_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_angle_first,
  output logic signed [15:0] out_angle_middle,
  output logic signed [15:0] out_angle_last,
  output logic               out_sine_clamped
);

  localparam logic signed [AW-1:0] QUARTER = AW'(34'sh040000000);
  localparam logic signed [SW-1:0] ONE_S = SW'(30'sh10000000);

  logic          adv;
  logic [NV-1:0] vpipe_r;
  logic          out_valid_r;

  logic signed [PW-1:0] xw_r, yz_r, zw_r, xy_r, xz_r, yw_r, xx_r, yy_r, zz_r, ww_r;
  side_t                side1_r, side2_r;
  logic [28:0]          mag_r;
  logic [VW-1:0]        v2_r;
  logic signed [34:0]   s_full;
  side_t                side1_nxt;

  sqrt_t   sq [SQRT_STAGES];
  side_t   side_r [SQRT_STAGES];
  cordic_t pre_nxt [3];
  cordic_t pre_r [3];
  cordic_t cc [RUN_STAGES][3];

  logic signed [AW-17:0] rnd [3];
  logic signed [15:0]    a_first_r, a_middle_r, a_last_r;
  logic                  clamp_out_r;
  side_t                 side_pre_r;

  assign adv = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vpipe_r <= {vpipe_r[NV-2:0], in_valid};
      out_valid_r <= vpipe_r[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xw_r <= PW'(in_quat_x) * PW'(in_quat_w);
      yz_r <= PW'(in_quat_y) * PW'(in_quat_z);
      zw_r <= PW'(in_quat_z) * PW'(in_quat_w);
      xy_r <= PW'(in_quat_x) * PW'(in_quat_y);
      xz_r <= PW'(in_quat_x) * PW'(in_quat_z);
      yw_r <= PW'(in_quat_y) * PW'(in_quat_w);
      xx_r <= PW'(in_quat_x) * PW'(in_quat_x);
      yy_r <= PW'(in_quat_y) * PW'(in_quat_y);
      zz_r <= PW'(in_quat_z) * PW'(in_quat_z);
      ww_r <= PW'(in_quat_w) * PW'(in_quat_w);
    end
  end

  always_comb begin
    s_full = 35'((CW'(xz_r) + CW'(yw_r)) <<< 1);
    side1_nxt.y1 = (CW'(xw_r) - CW'(yz_r)) <<< 1;
    side1_nxt.x1 = CW'(ww_r) - CW'(xx_r) - CW'(yy_r) + CW'(zz_r);
    side1_nxt.y3 = (CW'(zw_r) - CW'(xy_r)) <<< 1;
    side1_nxt.x3 = CW'(ww_r) + CW'(xx_r) - CW'(yy_r) - CW'(zz_r);
    if (s_full > 35'(ONE_S)) begin
      side1_nxt.s = ONE_S;
      side1_nxt.clamp = 1'b1;
    end else if (s_full < -35'(ONE_S)) begin
      side1_nxt.s = -ONE_S;
      side1_nxt.clamp = 1'b1;
    end else begin
      side1_nxt.s = SW'(s_full);
      side1_nxt.clamp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1_r <= side1_nxt;
      mag_r <= side1_nxt.s[SW-1] ? 29'(-side1_nxt.s) : 29'(side1_nxt.s);
      side2_r <= side1_r;
      v2_r <= (VW'(1) << 56) - VW'(mag_r) * VW'(mag_r);
    end
  end

  genvar k, l;
  generate
    for (k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      sqrt_t cin;
      if (k == 0) begin : g_first
        assign cin = '{v: v2_r, res: '0};
      end else begin : g_rest
        assign cin = sq[k-1];
      end
      q2e_sqrt_cell u_cell (
        .clk  (clk),
        .en   (adv),
        .stage(STG_W'(k)),
        .d_in (cin),
        .d_out(sq[k])
      );
      always_ff @(posedge clk) begin
        if (adv) begin
          side_r[k] <= (k == 0) ? side2_r : side_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  endgenerate

  function automatic cordic_t prerot(input logic signed [CW-1:0] y,
                                     input logic signed [CW-1:0] x);
    cordic_t r;
    r.zero = (x == '0) && (y == '0);
    if (x[CW-1]) begin
      if (!y[CW-1]) begin
        r.x = y;
        r.y = -x;
        r.acc = QUARTER;
      end else begin
        r.x = -y;
        r.y = x;
        r.acc = -QUARTER;
      end
    end else begin
      r.x = x;
      r.y = y;
      r.acc = '0;
    end
    return r;
  endfunction

  always_comb begin
    pre_nxt[0] = prerot(side_r[SQRT_STAGES-1].y1, side_r[SQRT_STAGES-1].x1);
    pre_nxt[1] = prerot(CW'(side_r[SQRT_STAGES-1].s),
                        CW'({1'b0, sq[SQRT_STAGES-1].res}));
    pre_nxt[2] = prerot(side_r[SQRT_STAGES-1].y3, side_r[SQRT_STAGES-1].x3);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r <= pre_nxt;
      side_pre_r <= side_r[SQRT_STAGES-1];
    end
  end

  logic clamp_dly_r [RUN_STAGES];

  generate
    for (k = 0; k < RUN_STAGES; k++) begin : g_cordic
      for (l = 0; l < 3; l++) begin : g_lane
        cordic_t cin;
        if (k == 0) begin : g_first
          assign cin = pre_r[l];
        end else begin : g_rest
          assign cin = cc[k-1][l];
        end
        q2e_cordic_cell u_cell (
          .clk  (clk),
          .en   (adv),
          .stage(STG_W'(k)),
          .d_in (cin),
          .d_out(cc[k][l])
        );
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          clamp_dly_r[k] <= (k == 0) ? side_pre_r.clamp : clamp_dly_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cc[RUN_STAGES-1][i].zero) begin
        rnd[i] = '0;
      end else begin
        rnd[i] = (AW-16)'((cc[RUN_STAGES-1][i].acc + AW'(32768)) >>> 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_first_r <= rnd[0][15:0];
      a_last_r <= rnd[2][15:0];
      if (rnd[1] > (AW-16)'(16384)) begin
        a_middle_r <= 16'sd16384;
      end else if (rnd[1] < -(AW-16)'(16384)) begin
        a_middle_r <= -16'sd16384;
      end else begin
        a_middle_r <= rnd[1][15:0];
      end
      clamp_out_r <= clamp_dly_r[RUN_STAGES-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle_first = a_first_r;
  assign out_angle_middle = a_middle_r;
  assign out_angle_last = a_last_r;
  assign out_sine_clamped = clamp_out_r;

  a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (a_middle_r <= 16'sd16384) && (a_middle_r >= -16'sd16384))
    else $error("middle angle out of range");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vpipe_r[0])
    else $error("accepted transaction not tracked");

  a_leave: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vpipe_r[NV-1]))
    else $error("result appeared without a transaction in flight");

endmodule
